>>> rtl/isu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isu_pkg: shared types and constants for the Ising spin update block
// Request codes, field widths, the evaluation result struct and the
// acceptance table round(65536 * exp(-k/16)) built at elaboration.
// ----------------------------------------------------------------------------
package isu_pkg;

  // field widths of the channel words
  localparam int REQ_W    = 2;
  localparam int IDX_IN_W = 4;
  localparam int CPL_IN_W = 16;
  localparam int RAND_W   = 16;
  localparam int BETA_W   = 16;
  localparam int ENERGY_W = 32;
  localparam int PACK_W   = 16;

  // request codes
  localparam logic [REQ_W-1:0] REQ_STEP  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CPL   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SPIN  = 2'd2;

  // reset value of beta (1.0 in Q8.8)
  localparam logic [BETA_W-1:0] BETA_RESET = 16'd256;

  // diff * beta stays below this bound whenever the table index is in range
  localparam int SMALL_W       = 23;
  localparam int PROD_W        = SMALL_W + BETA_W;
  localparam int X_SHIFT       = 15;
  localparam int EXP_ENTRIES   = 256;
  localparam int EXP_IDX_W     = 8;
  localparam int EXP_W         = 17;

  // saturation limits for the energy word
  localparam longint ENERGY_MAX = 64'sd2147483647;
  localparam longint ENERGY_MIN = -64'sd2147483648;

  // result of one acceptance evaluation
  typedef struct packed {
    logic done;
    logic accept;
  } eval_res_t;

  typedef logic [EXP_W-1:0] exp_tab_t [0:EXP_ENTRIES-1];

  // (a * b) >> 63 for a, b <= 2^63
  function automatic longint unsigned mul_q63(longint unsigned a, longint unsigned b);
    longint unsigned ah, al, bh, bl, lo, m1, m2, hi, mid, low64;
    ah  = a >> 32;
    al  = a & 64'h0000_0000_ffff_ffff;
    bh  = b >> 32;
    bl  = b & 64'h0000_0000_ffff_ffff;
    lo  = al * bl;
    m1  = ah * bl;
    m2  = al * bh;
    hi  = ah * bh;
    mid = (lo >> 32) + (m1 & 64'h0000_0000_ffff_ffff) + (m2 & 64'h0000_0000_ffff_ffff);
    hi  = hi + (m1 >> 32) + (m2 >> 32) + (mid >> 32);
    low64 = (mid << 32) | (lo & 64'h0000_0000_ffff_ffff);
    return (hi << 1) | (low64 >> 63);
  endfunction

  // exp(-k/16) in Q63 by series and repeated products, rounded to 1/65536
  function automatic exp_tab_t build_expt();
    longint unsigned term, ratio, v;
    exp_tab_t        t;
    term  = 64'h8000_0000_0000_0000;
    ratio = 64'h8000_0000_0000_0000;
    v     = 64'h8000_0000_0000_0000;
    for (int k = 1; k <= 16; k++) begin
      term = term / 64'(16 * k);
      if ((k % 2) == 1) begin
        ratio = ratio - term;
      end else begin
        ratio = ratio + term;
      end
    end
    for (int k = 0; k < EXP_ENTRIES; k++) begin
      t[k] = EXP_W'((v + (64'd1 << 46)) >> 47);
      v    = mul_q63(v, ratio);
    end
    return t;
  endfunction

  localparam exp_tab_t EXPT = build_expt();

endpackage

>>> rtl/isu_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isu_if: request and result channels of the spin update block
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface isu_in_if;
  import isu_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [REQ_W-1:0]           req_type;
  logic [IDX_IN_W-1:0]        row_index;
  logic [IDX_IN_W-1:0]        col_index;
  logic signed [CPL_IN_W-1:0] coupling_value;
  logic                       spin_value;
  logic [RAND_W-1:0]          random_value;

  modport source (
    output valid, req_type, row_index, col_index, coupling_value, spin_value,
           random_value,
    input  ready
  );
  modport sink (
    input  valid, req_type, row_index, col_index, coupling_value, spin_value,
           random_value,
    output ready
  );
endinterface

interface isu_out_if;
  import isu_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       flipped;
  logic signed [ENERGY_W-1:0] energy_change;
  logic [PACK_W-1:0]          spins_packed;

  modport source (
    output valid, flipped, energy_change, spins_packed,
    input  ready
  );
  modport sink (
    input  valid, flipped, energy_change, spins_packed,
    output ready
  );
endinterface

>>> rtl/isu_cpl_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isu_cpl_mem: coupling memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module isu_cpl_mem #(
  parameter int ADDR_W = 8,
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [0:DEPTH-1];
  logic [DATA_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/isu_accept.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isu_accept: Metropolis acceptance unit
// Stage one classifies the energy change and multiplies it by beta;
// stage two indexes the exponential table and compares the random word.
// ----------------------------------------------------------------------------
module isu_accept #(
  parameter int DW = 22
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic signed [DW-1:0]             diff,
  input  logic [isu_pkg::BETA_W-1:0]       beta,
  input  logic [isu_pkg::RAND_W-1:0]       rnd,
  output isu_pkg::eval_res_t               res
);
  import isu_pkg::*;

  localparam logic [1:0] DEC_TAKE   = 2'd0;
  localparam logic [1:0] DEC_REJECT = 2'd1;
  localparam logic [1:0] DEC_TABLE  = 2'd2;

  logic signed [63:0]   diff_ext;
  logic [SMALL_W-1:0]   diff_small;
  logic [1:0]           code;
  logic [PROD_W-1:0]    prod;

  logic                 s1_valid_r;
  logic [1:0]           s1_code_r;
  logic [PROD_W-1:0]    s1_prod_r;
  logic [RAND_W-1:0]    s1_rnd_r;

  logic [PROD_W-X_SHIFT-1:0] x_full;
  logic                 tab_hit;
  logic                 take;
  eval_res_t            res_r;

  // classify and multiply
  always_comb begin
    diff_ext   = 64'(diff);
    diff_small = diff_ext[SMALL_W-1:0];
    if (diff_ext <= 64'sd0 || beta == '0) begin
      code = DEC_TAKE;
    end else if (diff_ext >= (64'sd1 <<< SMALL_W)) begin
      code = DEC_REJECT;
    end else begin
      code = DEC_TABLE;
    end
    prod = PROD_W'(diff_small) * PROD_W'(beta);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      s1_code_r <= code;
      s1_prod_r <= prod;
      s1_rnd_r  <= rnd;
    end
  end

  // table lookup and compare
  always_comb begin
    x_full  = s1_prod_r[PROD_W-1:X_SHIFT];
    tab_hit = (x_full[PROD_W-X_SHIFT-1:EXP_IDX_W] == '0) &&
              (EXP_W'(s1_rnd_r) < EXPT[x_full[EXP_IDX_W-1:0]]);
    case (s1_code_r)
      DEC_TAKE:   take = 1'b1;
      DEC_TABLE:  take = tab_hit;
      default:    take = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r <= '0;
    end else begin
      res_r.done   <= s1_valid_r;
      res_r.accept <= s1_valid_r && take;
    end
  end

  assign res = res_r;

endmodule

>>> rtl/ising_metropolis_spin_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ising_metropolis_spin_update: Metropolis spin update for an Ising glass
// Holds SPINS spins and a SPINS x SPINS coupling memory; performs one
// Metropolis step per step request.
//
// Channels: in_ch takes one request word (step, coupling write or spin
// write); out_ch returns one result word per request with the flip flag,
// the proposed energy change (saturated to 32 bits) and the packed spins.
// cfg_wr_en/cfg_wr_data load beta (Q8.8); write only while idle.
// Timing: a step walks the coupling row one entry per cycle through the
// single memory read port and one accumulator, then passes the drain and
// difference states and the registered stages of the acceptance unit.
// A write request goes straight from idle to the result state.
// Reset: spins all -1, beta = 1.0, no result pending; the coupling memory
// is not cleared and must be written before it is used.
// Stall: the result sits in an output register; a further request is
// taken while it waits, and that request holds in its final cycle until
// the output register is free.
// ----------------------------------------------------------------------------
module ising_metropolis_spin_update #(
  parameter int SPINS         = 16,
  parameter int COUPLING_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  isu_in_if.sink                      in_ch,
  isu_out_if.source                   out_ch,
  input  logic                        cfg_wr_en,
  input  logic [isu_pkg::BETA_W-1:0]  cfg_wr_data
);
  import isu_pkg::*;

  localparam int IDX_W = $clog2(SPINS);
  localparam int FW    = COUPLING_BITS + IDX_W;
  localparam int DW    = FW + 3;
  localparam logic [IDX_W-1:0] CNT_LAST = IDX_W'(SPINS - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WALK  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_DIFF  = 3'd3;
  localparam logic [2:0] S_DEC   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]               state_r, state_nxt;
  logic [BETA_W-1:0]        beta_r;
  logic [SPINS-1:0]         spins_r;
  logic [IDX_W-1:0]         row_r;
  logic [IDX_W-1:0]         cnt_r;
  logic [RAND_W-1:0]        rnd_r;
  logic signed [FW-1:0]     acc_r, acc_nxt;
  logic signed [DW-1:0]     diff_r;
  logic                     flip_r;
  logic                     go_r;
  logic                     rd_valid_r;
  logic                     rd_skip_r;
  logic                     rd_spin_r;

  logic                     out_valid_r;
  logic                     out_flip_r;
  logic [ENERGY_W-1:0]      out_energy_r;
  logic [PACK_W-1:0]        out_spins_r;

  logic                     in_acc;
  logic                     out_load;
  logic                     row_ok_in;
  logic                     col_ok_in;
  logic [31:0]              row_ext;
  logic [31:0]              col_ext;
  logic [IDX_W-1:0]         row_in;
  logic [IDX_W-1:0]         col_in;
  logic signed [31:0]       cpl_ext;
  logic                     mem_we;
  logic [COUPLING_BITS-1:0] mem_rd_data;
  logic signed [COUPLING_BITS-1:0] cpl_q;
  logic signed [FW-1:0]     term;
  logic signed [DW-1:0]     quad;
  logic signed [63:0]       diff_ext;
  logic [ENERGY_W-1:0]      energy_sat;
  logic [PACK_W-1:0]        packed_spins;
  eval_res_t                eval_res;

  // request decode
  always_comb begin
    in_acc    = in_ch.valid && in_ch.ready;
    row_ext   = 32'(in_ch.row_index);
    col_ext   = 32'(in_ch.col_index);
    row_ok_in = row_ext < 32'(SPINS);
    col_ok_in = col_ext < 32'(SPINS);
    row_in    = row_ext[IDX_W-1:0];
    col_in    = col_ext[IDX_W-1:0];
    cpl_ext   = 32'(in_ch.coupling_value);
    mem_we    = in_acc && (in_ch.req_type == REQ_CPL) && row_ok_in && col_ok_in;
  end

  // coupling storage
  isu_cpl_mem #(
    .ADDR_W (2 * IDX_W),
    .DATA_W (COUPLING_BITS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr ({row_in, col_in}),
    .wr_data (cpl_ext[COUPLING_BITS-1:0]),
    .rd_en   (state_r == S_WALK),
    .rd_addr ({row_r, cnt_r}),
    .rd_data (mem_rd_data)
  );

  // local field accumulator, one coupling per cycle
  always_comb begin
    cpl_q = mem_rd_data;
    term  = FW'(cpl_q);
    if (!rd_valid_r || rd_skip_r) begin
      acc_nxt = acc_r;
    end else if (rd_spin_r) begin
      acc_nxt = acc_r + term;
    end else begin
      acc_nxt = acc_r - term;
    end
    quad = DW'(acc_r) <<< 2;
  end

  // acceptance evaluation
  isu_accept #(
    .DW (DW)
  ) u_accept (
    .clk   (clk),
    .rst_n (rst_n),
    .start (go_r),
    .diff  (diff_r),
    .beta  (beta_r),
    .rnd   (rnd_r),
    .res   (eval_res)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_ch.req_type == REQ_STEP && row_ok_in) begin
            state_nxt = S_WALK;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_WALK: begin
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: state_nxt = S_DIFF;
      S_DIFF:  state_nxt = S_DEC;
      S_DEC: begin
        if (eval_res.done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      beta_r      <= BETA_RESET;
      spins_r     <= '0;
      go_r        <= 1'b0;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      go_r       <= (state_r == S_DIFF);
      rd_valid_r <= (state_r == S_WALK);
      if (cfg_wr_en) begin
        beta_r <= cfg_wr_data;
      end
      if (in_acc && in_ch.req_type == REQ_SPIN && row_ok_in) begin
        spins_r[row_in] <= in_ch.spin_value;
      end
      if (state_r == S_DEC && eval_res.done && eval_res.accept) begin
        spins_r[row_r] <= ~spins_r[row_r];
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      row_r  <= row_in;
      rnd_r  <= in_ch.random_value;
      acc_r  <= '0;
      diff_r <= '0;
      flip_r <= 1'b0;
    end else begin
      acc_r <= acc_nxt;
      if (state_r == S_DIFF) begin
        diff_r <= spins_r[row_r] ? -quad : quad;
      end
      if (state_r == S_DEC && eval_res.done) begin
        flip_r <= eval_res.accept;
      end
    end
    if (state_r == S_WALK) begin
      cnt_r <= cnt_r + 1'b1;
    end else begin
      cnt_r <= '0;
    end
    rd_skip_r <= (cnt_r == row_r);
    rd_spin_r <= spins_r[cnt_r];
  end

  // saturate the energy change to 32 bits
  always_comb begin
    diff_ext = 64'(diff_r);
    if (diff_ext > ENERGY_MAX) begin
      energy_sat = ENERGY_W'(ENERGY_MAX);
    end else if (diff_ext < ENERGY_MIN) begin
      energy_sat = ENERGY_W'(ENERGY_MIN);
    end else begin
      energy_sat = diff_ext[ENERGY_W-1:0];
    end
  end

  // packed spin view, bits beyond SPINS read as zero
  for (genvar gi = 0; gi < PACK_W; gi++) begin : g_pack
    if (gi < SPINS) begin : g_on
      assign packed_spins[gi] = spins_r[gi];
    end else begin : g_off
      assign packed_spins[gi] = 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_flip_r   <= flip_r;
      out_energy_r <= energy_sat;
      out_spins_r  <= packed_spins;
    end
  end

  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.flipped       = out_flip_r;
  assign out_ch.energy_change = out_energy_r;
  assign out_ch.spins_packed  = out_spins_r;

endmodule

>>> rtl/isu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isu_checker: port-level checks for the spin update block
// Watches the request and result channels of the top level over time.
// ----------------------------------------------------------------------------
module isu_checker #(
  parameter int SPINS = 16
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           out_flipped,
  input logic [isu_pkg::ENERGY_W-1:0]   out_energy_change,
  input logic [isu_pkg::PACK_W-1:0]     out_spins_packed
);
  import isu_pkg::*;

  // no result survives reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a request keeps the block busy for at least the next cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken on consecutive cycles");

  // a new result never appears right after a request word is taken
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_valid && in_ready))
    else $error("result shown one cycle after request");

  // a stalled result holds
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_flipped) &&
    $stable(out_energy_change) && $stable(out_spins_packed))
    else $error("stalled result changed");

  // unused spin bits stay zero
  a_unused_spins: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((32'(out_spins_packed) >> SPINS) == 32'd0))
    else $error("spin bit beyond SPINS set");

endmodule

bind ising_metropolis_spin_update isu_checker #(
  .SPINS (SPINS)
) u_isu_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_flipped       (out_ch.flipped),
  .out_energy_change (out_ch.energy_change),
  .out_spins_packed  (out_ch.spins_packed)
);

>>> tb/ising_metropolis_spin_update_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ising_metropolis_spin_update_tb: self-checking bench for the spin update
// Loads the full coupling matrix and runs a short directed sequence. It then
// runs random step, coupling, spin and unused words under several beta
// settings and handshake idle patterns. Every result word is checked against
// a predictor that holds its own spins, couplings and acceptance table.
// ----------------------------------------------------------------------------
module ising_metropolis_spin_update_tb;
  import isu_pkg::*;

  localparam int NSPIN        = 16;
  localparam int CPL_BITS     = 16;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_WORDS  = 150;
  localparam int NUM_PHASES   = 7;

  // request code that the block takes and ignores
  localparam logic [REQ_W-1:0] REQ_NONE = 2'd3;

  typedef struct packed {
    logic [REQ_W-1:0]           req_type;
    logic [IDX_IN_W-1:0]        row_index;
    logic [IDX_IN_W-1:0]        col_index;
    logic signed [CPL_IN_W-1:0] coupling_value;
    logic                       spin_value;
    logic [RAND_W-1:0]          random_value;
  } req_word_t;

  typedef struct packed {
    logic                       flipped;
    logic signed [ENERGY_W-1:0] energy_change;
    logic [PACK_W-1:0]          spins_packed;
  } res_word_t;

  // spin glass predictor and queue of result words still owed by the block
  class spin_scoreboard;
    bit [NSPIN-1:0]             spin_state;
    logic signed [CPL_BITS-1:0] coupling [NSPIN][NSPIN];
    bit [BETA_W-1:0]            beta;
    bit [EXP_W-1:0]             accept_limit [EXP_ENTRIES];
    res_word_t                  owed_results [$];
    int                         errors;

    function new();
      longint unsigned term, ratio, v;
      bit [127:0]      prod;
      spin_state = '0;
      beta       = BETA_RESET;
      errors     = 0;
      // exp(-1/16) in Q63 from a Taylor series
      term  = 64'h8000_0000_0000_0000;
      ratio = term;
      v     = term;
      for (int k = 1; k <= 16; k++) begin
        term  = term / (64'd16 * k);
        ratio = (k % 2 == 1) ? ratio - term : ratio + term;
      end
      // powers of that ratio, rounded half up to 1/65536
      for (int k = 0; k < EXP_ENTRIES; k++) begin
        accept_limit[k] = EXP_W'((v + (64'd1 << 46)) >> 47);
        prod = {64'd0, v} * {64'd0, ratio};
        v    = prod[126:63];
      end
    endfunction

    function void set_beta(bit [BETA_W-1:0] b);
      beta = b;
    endfunction

    function int owed();
      return owed_results.size();
    endfunction

    // apply one accepted request word and queue the result it must produce
    function void note_request(req_word_t w);
      res_word_t       r;
      longint          field, d, c;
      longint unsigned x;
      bit              take;
      r = '0;
      case (w.req_type)
        REQ_CPL: begin
          coupling[w.row_index][w.col_index] = w.coupling_value;
        end
        REQ_SPIN: begin
          spin_state[w.row_index] = w.spin_value;
        end
        REQ_STEP: begin
          // local field over the row, diagonal skipped
          field = 0;
          for (int j = 0; j < NSPIN; j++) begin
            if (j != w.row_index) begin
              c     = coupling[w.row_index][j];
              field = spin_state[j] ? field + c : field - c;
            end
          end
          d = spin_state[w.row_index] ? -4 * field : 4 * field;
          if (d <= 0) begin
            take = 1'b1;
          end else begin
            x = ($unsigned(d) * beta) >> X_SHIFT;
            if (x < EXP_ENTRIES) begin
              take = w.random_value < accept_limit[x];
            end else begin
              take = 1'b0;
            end
          end
          if (take) begin
            spin_state[w.row_index] ^= 1'b1;
          end
          r.flipped = take;
          // energy word saturates, decision above used the exact value
          if (d > ENERGY_MAX) d = ENERGY_MAX;
          if (d < ENERGY_MIN) d = ENERGY_MIN;
          r.energy_change = ENERGY_W'(d);
        end
        default: ;
      endcase
      r.spins_packed = spin_state;
      owed_results.push_back(r);
    endfunction

    // compare one accepted result word with the oldest one owed
    function void check_result(logic f, logic signed [ENERGY_W-1:0] e,
                               logic [PACK_W-1:0] s);
      res_word_t want;
      if (owed_results.size() == 0) begin
        $error("unexpected result word: flipped %0d energy_change %0d spins_packed %h",
               f, e, s);
        errors++;
        return;
      end
      want = owed_results.pop_front();
      if (f !== want.flipped) begin
        $error("flipped: expected %0d, actual %0d", want.flipped, f);
        errors++;
      end
      if (e !== want.energy_change) begin
        $error("energy_change: expected %0d, actual %0d", want.energy_change, e);
        errors++;
      end
      if (s !== want.spins_packed) begin
        $error("spins_packed: expected %h, actual %h", want.spins_packed, s);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [BETA_W-1:0] cfg_wr_data;
  int                in_idle_pct  = 0;
  int                out_idle_pct = 0;
  int                stall_cycles = 0;
  spin_scoreboard    sb = new();
  req_word_t         directed [$];
  bit [BETA_W-1:0]   phase_beta [NUM_PHASES];

  isu_in_if  in_ch ();
  isu_out_if out_ch ();

  ising_metropolis_spin_update #(
    .SPINS        (NSPIN),
    .COUPLING_BITS(CPL_BITS)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // coupling values: mostly small so the acceptance table is reached
  function automatic logic signed [CPL_IN_W-1:0] random_coupling();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return CPL_IN_W'(int'($urandom_range(0, 2047)) - 1024);
    if (pick < 80) return CPL_IN_W'(int'($urandom_range(0, 127)) - 64);
    if (pick < 90) return CPL_IN_W'($urandom_range(0, 65535));
    case ($urandom_range(0, 3))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'sh0000;
      default: return 16'shffff;
    endcase
  endfunction

  function automatic req_word_t make_word(logic [REQ_W-1:0] req, int row, int col,
                                          logic signed [CPL_IN_W-1:0] cpl, bit spin,
                                          logic [RAND_W-1:0] rnd);
    req_word_t w;
    w.req_type       = req;
    w.row_index      = IDX_IN_W'(row);
    w.col_index      = IDX_IN_W'(col);
    w.coupling_value = cpl;
    w.spin_value     = spin;
    w.random_value   = rnd;
    return w;
  endfunction

  function automatic req_word_t random_request();
    req_word_t w;
    int        pick;
    pick = $urandom_range(0, 99);
    w.req_type = (pick < 55) ? REQ_STEP : (pick < 80) ? REQ_CPL :
                 (pick < 97) ? REQ_SPIN : REQ_NONE;
    w.row_index      = IDX_IN_W'($urandom_range(0, NSPIN - 1));
    w.col_index      = IDX_IN_W'($urandom_range(0, NSPIN - 1));
    w.coupling_value = random_coupling();
    w.spin_value     = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 9);
    w.random_value = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hffff :
                     RAND_W'($urandom_range(0, 65535));
    return w;
  endfunction

  // drive one request word from a falling edge until it is taken
  task automatic send_word(input req_word_t w);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.req_type       <= w.req_type;
    in_ch.row_index      <= w.row_index;
    in_ch.col_index      <= w.col_index;
    in_ch.coupling_value <= w.coupling_value;
    in_ch.spin_value     <= w.spin_value;
    in_ch.random_value   <= w.random_value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_request(w);
    @(negedge clk);
  endtask

  // stop sending and wait until every result word has come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.owed() != 0) @(negedge clk);
  endtask

  // beta write, only while the block is idle
  task automatic write_beta(input bit [BETA_W-1:0] b);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= b;
    @(posedge clk);
    sb.set_beta(b);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // receiver side ready, changed at falling edges
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(0, 99) >= out_idle_pct);
    end
  end

  // result checking
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_result(out_ch.flipped, out_ch.energy_change, out_ch.spins_packed);
    end
  end

  // watchdog on cycles without any word moving
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // stimulus
  initial begin
    rst_n                = 1'b0;
    cfg_wr_en            = 1'b0;
    cfg_wr_data          = '0;
    in_ch.valid          = 1'b0;
    in_ch.req_type       = REQ_STEP;
    in_ch.row_index      = '0;
    in_ch.col_index      = '0;
    in_ch.coupling_value = '0;
    in_ch.spin_value     = 1'b0;
    in_ch.random_value   = '0;
    in_idle_pct          = 37;
    out_idle_pct         = 56;
    phase_beta = '{16'd256, 16'd0, 16'hffff, 16'd16, 16'd1024, 16'd256, 16'd1};
    phase_beta[5] = BETA_W'($urandom_range(2, 65534));

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // load every coupling: row 0 most negative, row 1 most positive,
    // row 4 zero (zero energy change), row 5 slightly negative
    for (int r = 0; r < NSPIN; r++) begin
      for (int c = 0; c < NSPIN; c++) begin
        send_word(make_word(REQ_CPL, r, c,
                            (r == 0) ? 16'sh8000 : (r == 1) ? 16'sh7fff :
                            (r == 4) ? 16'sh0000 : (r == 5) ? -16'sd8 :
                            random_coupling(), 1'(c % 2), 16'(c * 4099)));
      end
    end

    // directed words at reset beta
    directed.push_back(make_word(REQ_STEP, 0, 0, '0, 1'b0, 16'h0000));   // far above table
    directed.push_back(make_word(REQ_STEP, 1, 0, '0, 1'b0, 16'hffff));   // negative change
    directed.push_back(make_word(REQ_STEP, 4, 0, '0, 1'b0, 16'hffff));   // zero change
    directed.push_back(make_word(REQ_STEP, 5, 0, '0, 1'b0, 16'hffff));
    directed.push_back(make_word(REQ_STEP, 5, 0, '0, 1'b0, 16'h0000));
    directed.push_back(make_word(REQ_SPIN, 15, 0, '0, 1'b1, 16'h0000));
    directed.push_back(make_word(REQ_SPIN, 0, 15, '0, 1'b1, 16'hffff));
    directed.push_back(make_word(REQ_SPIN, 0, 0, '0, 1'b0, 16'h0000));
    directed.push_back(make_word(REQ_NONE, 15, 15, 16'shffff, 1'b1, 16'hffff));
    directed.push_back(make_word(REQ_NONE, 0, 0, 16'sh0000, 1'b0, 16'h0000));
    directed.push_back(make_word(REQ_CPL, 2, 2, 16'sh7fff, 1'b0, 16'h0000)); // diagonal
    directed.push_back(make_word(REQ_STEP, 2, 2, '0, 1'b0, 16'h8000));
    directed.push_back(make_word(REQ_CPL, 15, 15, 16'sh8000, 1'b1, 16'hffff));
    directed.push_back(make_word(REQ_CPL, 0, 15, 16'sh0000, 1'b0, 16'h0000));
    directed.push_back(make_word(REQ_CPL, 15, 0, 16'sh0001, 1'b1, 16'h0001));
    directed.push_back(make_word(REQ_STEP, 15, 0, '0, 1'b0, 16'h0000));
    directed.push_back(make_word(REQ_STEP, 15, 0, '0, 1'b0, 16'hffff));
    directed.push_back(make_word(REQ_STEP, 1, 0, '0, 1'b0, 16'h0000));
    directed.push_back(make_word(REQ_SPIN, 1, 0, '0, 1'b0, 16'h0000));
    directed.push_back(make_word(REQ_STEP, 3, 0, '0, 1'b0, 16'h0000));
    foreach (directed[i]) send_word(directed[i]);
    drain();

    // random phases, each with its own beta and one of three idle patterns
    for (int p = 1; p < NUM_PHASES; p++) begin
      if (p == 1) begin
        in_idle_pct  = 37;
        out_idle_pct = 56;
      end else if (p < 4) begin
        in_idle_pct  = 56;
        out_idle_pct = 37;
      end else begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      write_beta(phase_beta[p]);
      repeat (PHASE_WORDS + $urandom_range(0, 40)) send_word(random_request());
      drain();
    end

    // let any stray result word show up
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.owed() != 0) begin
      $error("%0d result words never arrived", sb.owed());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
